### rtl/core/ipv4hb_pkg.sv
// ipv4hb_pkg: types, constants and checksum helpers for the ipv4 header builder
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package ipv4hb_pkg;

   // header run length and byte index width
   localparam int unsigned HdrBytes = 22;
   localparam int unsigned IdxWidth = $clog2(HdrBytes);
   localparam logic [IdxWidth-1:0] LastIdx = IdxWidth'(HdrBytes - 1);

   // fixed header content
   localparam logic [7:0]  EtherTypeHi = 8'h08;
   localparam logic [7:0]  EtherTypeLo = 8'h00;
   localparam logic [7:0]  VersionIhl  = 8'h45;
   localparam logic [7:0]  TimeToLive  = 8'd128;
   localparam logic [15:0] HdrLength   = 16'd20;
   localparam logic [15:0] CksumMask   = 16'hFFFF;

   // request word layout, lowest bit first
   localparam int unsigned ReqWidth = 56;

   // partial sums of the checksum
   localparam int unsigned SumWidth  = 18;
   localparam int unsigned FullWidth = SumWidth + 1;

   // one header as it goes to the serializer
   typedef struct packed {
      logic [15:0] total_length;
      logic [7:0]  ident;
      logic [7:0]  protocol;
      logic [15:0] cksum;
      logic [31:0] source_address;
      logic [31:0] dest_address;
   } hdr_type;

   // load handshake between the request slot and the serializer
   typedef struct packed {
      logic    valid;
      hdr_type hdr;
   } load_type;

   // end-around carry fold of a partial sum, then complement
   function automatic logic [15:0] cksum_fold(input logic [FullWidth-1:0] sum);
      logic [16:0] s1;
      logic [16:0] s2;
      s1 = {1'b0, sum[15:0]} + 17'(sum[FullWidth-1:16]);
      s2 = {1'b0, s1[15:0]} + 17'(s1[16]);
      return (~s2[15:0]) & CksumMask;
   endfunction

endpackage

### rtl/core/ipv4hb_ser.sv
// ipv4hb_ser: turns one header into its 22-byte word run with an output register
// depends on ipv4hb_pkg
`timescale 1ns / 1ps

module ipv4hb_ser (
   input  logic                 clock,
   input  logic                 reset,
   input  ipv4hb_pkg::load_type load,
   output logic                 load_ready,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [7:0]           rsp_tdata,   // out_byte [7:0]
   output logic                 rsp_tlast    // last
);
   import ipv4hb_pkg::*;

   hdr_type               hdr_ff, hdr_in;
   logic [IdxWidth-1:0]   idx_ff, idx_in;
   logic                  active_ff, active_in;
   logic                  valid_ff, valid_in;
   logic [7:0]            data_ff, data_in;
   logic                  last_ff, last_in;
   logic                  out_free;
   logic                  emit;
   logic [7:0]            cur_byte;

   // byte select for the current position
   always_comb begin
      unique case (idx_ff)
         5'd0:    cur_byte = EtherTypeHi;
         5'd1:    cur_byte = EtherTypeLo;
         5'd2:    cur_byte = VersionIhl;
         5'd3:    cur_byte = 8'h00;
         5'd4:    cur_byte = hdr_ff.total_length[15:8];
         5'd5:    cur_byte = hdr_ff.total_length[7:0];
         5'd6:    cur_byte = 8'h00;
         5'd7:    cur_byte = hdr_ff.ident;
         5'd8:    cur_byte = 8'h00;
         5'd9:    cur_byte = 8'h00;
         5'd10:   cur_byte = TimeToLive;
         5'd11:   cur_byte = hdr_ff.protocol;
         5'd12:   cur_byte = hdr_ff.cksum[15:8];
         5'd13:   cur_byte = hdr_ff.cksum[7:0];
         5'd14:   cur_byte = hdr_ff.source_address[31:24];
         5'd15:   cur_byte = hdr_ff.source_address[23:16];
         5'd16:   cur_byte = hdr_ff.source_address[15:8];
         5'd17:   cur_byte = hdr_ff.source_address[7:0];
         5'd18:   cur_byte = hdr_ff.dest_address[31:24];
         5'd19:   cur_byte = hdr_ff.dest_address[23:16];
         5'd20:   cur_byte = hdr_ff.dest_address[15:8];
         5'd21:   cur_byte = hdr_ff.dest_address[7:0];
         default: cur_byte = 8'h00;
      endcase
   end

   // advance when the output register is empty or being drained
   assign out_free   = !valid_ff || rsp_tready;
   assign emit       = active_ff && out_free;
   assign load_ready = !active_ff || (emit && (idx_ff == LastIdx));

   // next state of the run and the output register
   always_comb begin
      hdr_in    = hdr_ff;
      idx_in    = idx_ff;
      active_in = active_ff;
      valid_in  = valid_ff;
      data_in   = data_ff;
      last_in   = last_ff;
      if (out_free) begin
         valid_in = 1'b0;
      end
      if (emit) begin
         valid_in  = 1'b1;
         data_in   = cur_byte;
         last_in   = (idx_ff == LastIdx);
         idx_in    = idx_ff + 1'b1;
         if (idx_ff == LastIdx) begin
            active_in = 1'b0;
         end
      end
      if (load.valid && load_ready) begin
         hdr_in    = load.hdr;
         idx_in    = '0;
         active_in = 1'b1;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         valid_ff  <= 1'b0;
         idx_ff    <= '0;
      end else begin
         active_ff <= active_in;
         valid_ff  <= valid_in;
         idx_ff    <= idx_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      hdr_ff  <= hdr_in;
      data_ff <= data_in;
      last_ff <= last_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tlast  = last_ff;

endmodule

### rtl/core/ipv4_header_builder.sv
// ipv4_header_builder: top level, request slot, id counter and source register
// depends on ipv4hb_pkg and ipv4hb_ser
`timescale 1ns / 1ps

// Usage
// req channel: one word per header, tdata holds dest_address [31:0],
//   payload_length [47:32] and protocol [55:48].
// rsp channel: 22 words per request, one byte each: EtherType 0x0800 then
//   the 20-byte IPv4 header in network order, tlast on the 22nd byte.
// csr port: csr_wen writes the own IPv4 source address from csr_wdata.
// A request goes from the request slot into the serializer, then out through its output register.
// The byte-wide result channel limits the request rate; the request slot
//   takes the next word while the current run is still going out, so runs
//   follow each other back to back while rsp does not stall.
// The identification field comes from an 8-bit counter that steps on each
//   accepted request and wraps.
// Reset clears the counter, the source address and all valid flags.
// A stall on rsp holds the current byte; req_tready is low while the slot
//   holds a word, from the cycle after an accept until the serializer takes it.

module ipv4_header_builder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [ipv4hb_pkg::ReqWidth-1:0] req_tdata,   // dest_address, payload_length, protocol
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // out_byte
   output logic        rsp_tlast,   // last
   input  logic        csr_wen,
   input  logic [31:0] csr_wdata    // source_address
);
   import ipv4hb_pkg::*;

   logic [31:0]         src_ff;
   logic [SumWidth-1:0] src_sum_ff;
   logic [7:0]          id_ff;
   logic                slot_valid_ff, slot_valid_in;
   logic [31:0]         dst_ff;
   logic [15:0]         total_ff;
   logic [7:0]          proto_ff;
   logic [7:0]          slot_id_ff;
   logic [SumWidth-1:0] sum_ff;
   logic                req_fire;
   logic [15:0]         total_in;
   logic [SumWidth-1:0] sum_in;
   logic                load_ready;
   load_type            load;

   assign req_tready = !slot_valid_ff;
   assign req_fire   = req_tvalid && req_tready;

   // request fields and the request part of the checksum
   assign total_in = req_tdata[47:32] + HdrLength;
   assign sum_in   = SumWidth'(req_tdata[31:16]) + SumWidth'(req_tdata[15:0])
                   + SumWidth'(total_in) + SumWidth'(req_tdata[55:48])
                   + SumWidth'(id_ff);

   // slot occupancy
   always_comb begin
      slot_valid_in = slot_valid_ff;
      if (load.valid && load_ready) begin
         slot_valid_in = 1'b0;
      end
      if (req_fire) begin
         slot_valid_in = 1'b1;
      end
   end

   // control registers and config
   always_ff @(posedge clock) begin
      if (reset) begin
         slot_valid_ff <= 1'b0;
         id_ff         <= '0;
         src_ff        <= '0;
         src_sum_ff    <= SumWidth'({VersionIhl, 8'h00}) + SumWidth'({TimeToLive, 8'h00});
      end else begin
         slot_valid_ff <= slot_valid_in;
         if (req_fire) begin
            id_ff <= id_ff + 1'b1;
         end
         if (csr_wen) begin
            src_ff     <= csr_wdata;
            src_sum_ff <= SumWidth'(csr_wdata[31:16]) + SumWidth'(csr_wdata[15:0])
                        + SumWidth'({VersionIhl, 8'h00}) + SumWidth'({TimeToLive, 8'h00});
         end
      end
   end

   // slot payload
   always_ff @(posedge clock) begin
      if (req_fire) begin
         dst_ff     <= req_tdata[31:0];
         total_ff   <= total_in;
         proto_ff   <= req_tdata[55:48];
         slot_id_ff <= id_ff;
         sum_ff     <= sum_in;
      end
   end

   // finished header toward the serializer
   always_comb begin
      load.valid              = slot_valid_ff;
      load.hdr.total_length   = total_ff;
      load.hdr.ident          = slot_id_ff;
      load.hdr.protocol       = proto_ff;
      load.hdr.cksum          = cksum_fold(FullWidth'(sum_ff) + FullWidth'(src_sum_ff));
      load.hdr.source_address = src_ff;
      load.hdr.dest_address   = dst_ff;
   end

   ipv4hb_ser u_ser (
      .clock      (clock),
      .reset      (reset),
      .load       (load),
      .load_ready (load_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

### rtl/core/ipv4hb_checker.sv
// ipv4hb_checker: port-level assertions on the ipv4 header builder, with bind
// depends on ipv4hb_pkg; attaches to ipv4_header_builder
`timescale 1ns / 1ps

module ipv4hb_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tlast
);
   import ipv4hb_pkg::*;

   logic [IdxWidth-1:0] pos_ff;

   // position of the next result word inside its run
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else if (rsp_tvalid && rsp_tready) begin
         pos_ff <= (pos_ff == LastIdx) ? '0 : pos_ff + 1'b1;
      end
   end

   // nothing shown right after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("rsp_tvalid high after reset");

   // a stalled word holds
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled rsp word changed");

   // tlast marks exactly the 22nd word
   a_last_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tlast == (pos_ff == LastIdx)))
      else $error("rsp_tlast out of place");

   // every run opens with the high ethertype byte and carries the version byte third
   a_run_head: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && ((pos_ff == 5'd0 && rsp_tdata != EtherTypeHi)
                  || (pos_ff == 5'd2 && rsp_tdata != VersionIhl)) |-> 1'b0)
      else $error("bad fixed header byte");

endmodule

bind ipv4_header_builder ipv4hb_checker u_ipv4hb_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

### dv/ipv4_header_builder_test.sv
// ipv4_header_builder_test: self-checking testbench for the ipv4 header builder
// predicts every EtherType and header byte from the request word and the source address
// depends on ipv4hb_pkg and the ipv4_header_builder rtl
`timescale 1ns / 1ps

module ipv4_header_builder_test;

   import ipv4hb_pkg::*;

   // one expected byte of a header run
   typedef struct {
      logic [7:0] value;
      logic       last;
   } hdr_byte_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [55:0] req_tdata = '0;   // dest_address, payload_length, protocol
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;        // out_byte
   logic        rsp_tlast;        // last
   logic        csr_wen = 1'b0;
   logic [31:0] csr_wdata = '0;   // source_address

   // predictor state and scoreboard
   hdr_byte_type expected_bytes[$];
   logic [31:0] own_address = '0;
   logic [7:0]  ident_count = '0;
   logic        idle_on = 1'b1;
   int unsigned requests_sent = 0;
   int unsigned bytes_checked = 0;
   int unsigned address_writes = 0;
   int unsigned mismatches = 0;

   ipv4_header_builder u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata)
   );

   always #2 clock = ~clock;

   // fail-safe end of run
   initial begin
      #2_000_000;
      $display("timeout: %0d requests sent, %0d bytes still expected",
               requests_sent, expected_bytes.size());
      $display("CHECKS FAILED");
      $finish;
   end

   // build the 22 bytes of one request and queue them
   function automatic void predict_header(input logic [31:0] dest, input logic [15:0] plen,
                                          input logic [7:0] proto);
      logic [7:0]  hb [0:HdrBytes-1];
      logic [15:0] total;
      logic [31:0] acc;
      logic [15:0] cksum;
      hdr_byte_type entry;
      total = plen + 16'd20;   // wraps for oversize payloads
      hb[0]  = 8'h08;
      hb[1]  = 8'h00;
      hb[2]  = 8'h45;
      hb[3]  = 8'h00;
      hb[4]  = total[15:8];
      hb[5]  = total[7:0];
      hb[6]  = 8'h00;
      hb[7]  = ident_count;
      hb[8]  = 8'h00;
      hb[9]  = 8'h00;
      hb[10] = 8'd128;
      hb[11] = proto;
      hb[12] = 8'h00;
      hb[13] = 8'h00;
      hb[14] = own_address[31:24];
      hb[15] = own_address[23:16];
      hb[16] = own_address[15:8];
      hb[17] = own_address[7:0];
      hb[18] = dest[31:24];
      hb[19] = dest[23:16];
      hb[20] = dest[15:8];
      hb[21] = dest[7:0];
      // ones-complement sum over the header words, carries folded back in
      acc = '0;
      for (int i = 2; i < HdrBytes; i += 2)
         acc += {16'h0000, hb[i], hb[i+1]};
      acc = {16'h0000, acc[15:0]} + {16'h0000, acc[31:16]};
      acc = {16'h0000, acc[15:0]} + {16'h0000, acc[31:16]};
      cksum = ~acc[15:0];
      hb[12] = cksum[15:8];
      hb[13] = cksum[7:0];
      for (int i = 0; i < HdrBytes; i++) begin
         entry.value = hb[i];
         entry.last  = (i == HdrBytes - 1);
         expected_bytes.push_back(entry);
      end
      ident_count = ident_count + 8'd1;
   endfunction

   task automatic note_mismatch(input string what, input logic [7:0] exp_v,
                                input logic [7:0] act_v);
      mismatches++;
      if (mismatches <= 10)
         $display("mismatch at %0t: %s expected %02h got %02h (byte %0d)",
                  $time, what, exp_v, act_v, bytes_checked);
   endtask

   // send one request word, idling at random first
   task automatic send_request(input logic [31:0] dest, input logic [15:0] plen,
                               input logic [7:0] proto);
      while (idle_on && $urandom_range(99) < 38) begin
         req_tvalid <= 1'b0;
         req_tdata  <= 56'({$urandom(), $urandom()});
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {proto, plen, dest};
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      predict_header(dest, plen, proto);
      requests_sent++;
   endtask

   // let every queued byte come out, then let the clock run on with req_tvalid low
   task automatic wait_for_idle();
      req_tvalid <= 1'b0;
      while (expected_bytes.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // source address write, only while the block is idle
   task automatic write_source(input logic [31:0] addr);
      csr_wen   <= 1'b1;
      csr_wdata <= addr;
      @(posedge clock);
      csr_wen   <= 1'b0;
      own_address = addr;
      address_writes++;
      @(posedge clock);
   endtask

   // source address straight out of reset
   task automatic test_reset_source();
      send_request(32'h0A000001, 16'd40, 8'd6);
      send_request(32'h00000000, 16'd0, 8'd0);
      wait_for_idle();
   endtask

   // extremes of every field, including oversize payload lengths that wrap
   task automatic test_field_extremes();
      write_source(32'hFFFFFFFF);
      send_request(32'hFFFFFFFF, 16'd65515, 8'd255);
      send_request(32'h00000000, 16'd0, 8'd0);
      send_request(32'hFFFFFFFF, 16'd65516, 8'd17);
      send_request(32'h80000001, 16'd65535, 8'd1);
      send_request(32'h7FFFFFFE, 16'h8000, 8'h80);
      send_request(32'hAAAAAAAA, 16'h5555, 8'hAA);
      send_request(32'h55555555, 16'hAAAA, 8'h55);
      wait_for_idle();
   endtask

   // common protocols and sizes on a private source address
   task automatic test_common_traffic();
      write_source(32'hC0A80001);
      send_request(32'hC0A80002, 16'd20, 8'd6);
      send_request(32'h08080808, 16'd8, 8'd17);
      send_request(32'hE0000001, 16'd64, 8'd1);
      send_request(32'hC0A800FF, 16'd1480, 8'd6);
      send_request(32'h0A0A0A0A, 16'd1, 8'd17);
      wait_for_idle();
   endtask

   // random requests; mostly typical sizes, some full range and edges
   task automatic test_random_traffic(input int unsigned count);
      logic [31:0] dest;
      logic [15:0] plen;
      logic [7:0]  proto;
      int unsigned pick;
      for (int unsigned n = 0; n < count; n++) begin
         dest = $urandom();
         pick = $urandom_range(99);
         if (pick < 65)
            plen = 16'($urandom_range(0, 1500));
         else if (pick < 90)
            plen = 16'($urandom_range(0, 65535));
         else begin
            case ($urandom_range(3))
               0: plen = 16'd0;
               1: plen = 16'd65515;
               2: plen = 16'd65516;
               default: plen = 16'd65535;
            endcase
         end
         if ($urandom_range(1) == 0) begin
            case ($urandom_range(2))
               0: proto = 8'd1;
               1: proto = 8'd6;
               default: proto = 8'd17;
            endcase
         end else begin
            proto = 8'($urandom_range(0, 255));
         end
         send_request(dest, plen, proto);
      end
      wait_for_idle();
   endtask

   // result side stalls at random unless idling is switched off
   always @(posedge clock)
      rsp_tready <= !idle_on || ($urandom_range(99) >= 38);

   // compare each accepted byte against the oldest expectation
   always @(posedge clock) begin
      hdr_byte_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_bytes.size() == 0) begin
            note_mismatch("unexpected byte", 8'h00, rsp_tdata);
         end else begin
            want = expected_bytes.pop_front();
            if (rsp_tdata !== want.value)
               note_mismatch("out_byte", want.value, rsp_tdata);
            if (rsp_tlast !== want.last)
               note_mismatch("last", {7'd0, want.last}, {7'd0, rsp_tlast});
         end
         bytes_checked++;
      end
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_source();
      test_field_extremes();
      test_common_traffic();

      write_source($urandom());
      test_random_traffic(92);
      // long stretch with both sides running flat out
      write_source(32'h00000000);
      idle_on = 1'b0;
      test_random_traffic(92);
      idle_on = 1'b1;
      write_source(32'hFFFFFFFF);
      test_random_traffic(92);
      write_source($urandom());
      test_random_traffic(92);

      if (expected_bytes.size() != 0) begin
         mismatches += expected_bytes.size();
         $display("%0d expected bytes never arrived", expected_bytes.size());
      end
      $display("covered %0d header requests (%0d bytes) over %0d source addresses,",
               requests_sent, bytes_checked, address_writes);
      $display("field extremes, oversize lengths and id counter wrap; %0d mismatches",
               mismatches);
      if (mismatches == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

### files.f
rtl/core/ipv4hb_pkg.sv
rtl/core/ipv4hb_ser.sv
rtl/core/ipv4_header_builder.sv
rtl/core/ipv4hb_checker.sv
dv/ipv4_header_builder_test.sv
